// ===== rtl/hsa_pkg.sv =====
`timescale 1ns / 1ps
package hsa_pkg;

   localparam int VAL_W       = 32;
   localparam int IDX_W       = 6;
   localparam int ADDR_W      = 6;
   localparam int MAX_ROW_DEF = 64;

   localparam logic ASCENDING = 1'b0;

   // write data select for the pair store
   localparam logic [1:0] WSEL_INPUT = 2'd0;
   localparam logic [1:0] WSEL_HOLD  = 2'd1;
   localparam logic [1:0] WSEL_PICK  = 2'd2;
   localparam logic [1:0] WSEL_RDA   = 2'd3;

   // hold register load select
   localparam logic HSEL_RDA = 1'b0;
   localparam logic HSEL_RDB = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] index;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [1:0]        wr_sel;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_a;
      logic [ADDR_W-1:0] rd_b;
      logic              hold_ld;
      logic              hold_sel;
      logic              right_ok;
      logic              desc;
      logic              out_ld;
      logic              out_end;
      logic              out_ovf;
   } cmd_type;

   typedef struct packed {
      logic pick_right;
      logic sift_on;
   } sts_type;

   // C float a < b: false on NaN, -0 equals +0
   function automatic logic f32_lt(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic a_nan;
      logic b_nan;
      logic zeros;
      logic res;
      a_nan = (&a[30:23]) && (|a[22:0]);
      b_nan = (&b[30:23]) && (|b[22:0]);
      zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (a_nan || b_nan || zeros) begin
         res = 1'b0;
      end else if (a[31] && !b[31]) begin
         res = 1'b1;
      end else if (!a[31] && b[31]) begin
         res = 1'b0;
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

   // true when a must sit below b in the heap order
   function automatic logic heap_before(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                        logic desc);
      return (desc == ASCENDING) ? f32_lt(a, b) : f32_lt(b, a);
   endfunction

endpackage

// ===== rtl/hsa_req_if.sv =====
`timescale 1ns / 1ps
interface hsa_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

// ===== rtl/hsa_rsp_if.sv =====
`timescale 1ns / 1ps
interface hsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sorted_value;
   logic [5:0]  source_index;
   logic        end_of_row;
   logic        overflow;

   modport source (output valid, output sorted_value, output source_index,
                   output end_of_row, output overflow, input ready);
   modport sink (input valid, input sorted_value, input source_index,
                 input end_of_row, input overflow, output ready);
endinterface

// ===== rtl/heap_argsort.sv =====
`timescale 1ns / 1ps
// Sort: after the last request of a row, the controller builds the heap and then
//   pops the root to the end of the store until the heap is empty; results then leave
//   one at a time: read, load the result register, wait until the sink takes it.
// Throughput: one request per cycle while a row is collected; each heap level reads
//   both children, then compares and writes back, on the one-write store.
// Reset: synchronous, active high; clears row count, drop flag and sort mode.
module heap_argsort #(
   parameter int MAX_ROW = hsa_pkg::MAX_ROW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   hsa_req_if.sink          req_ch,
   hsa_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   import hsa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller: collects the row, walks build and pop phases of the heap,
   // then reads the sorted pairs out one at a time.
   hsa_ctrl #(
      .MAX_ROW (MAX_ROW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: value/index store, sift hold register, float compares and
   // the result register that holds a result until the sink takes it.
   hsa_datapath #(
      .MAX_ROW (MAX_ROW)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .sts       (sts),
      .req_value (req_ch.value),
      .out_value (rsp_ch.sorted_value),
      .out_index (rsp_ch.source_index),
      .out_end   (rsp_ch.end_of_row),
      .out_ovf   (rsp_ch.overflow)
   );

endmodule

// ===== rtl/hsa_datapath.sv =====
`timescale 1ns / 1ps
module hsa_datapath #(
   parameter int MAX_ROW = hsa_pkg::MAX_ROW_DEF
) (
   input  logic                      clock,
   input  hsa_pkg::cmd_type          cmd,
   output hsa_pkg::sts_type          sts,
   input  logic [hsa_pkg::VAL_W-1:0] req_value,
   output logic [hsa_pkg::VAL_W-1:0] out_value,
   output logic [hsa_pkg::IDX_W-1:0] out_index,
   output logic                      out_end,
   output logic                      out_ovf
);
   import hsa_pkg::*;

   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

   entry_type mem [MAX_ROW];
   entry_type rda_ff;
   entry_type rdb_ff;
   entry_type hold_ff;
   entry_type hold_in;
   entry_type pick;
   entry_type wdata;
   logic      pick_right;

   assign pick_right = cmd.right_ok && heap_before(rda_ff.value, rdb_ff.value, cmd.desc);
   assign pick       = pick_right ? rdb_ff : rda_ff;
   assign sts.pick_right = pick_right;
   assign sts.sift_on    = heap_before(hold_ff.value, pick.value, cmd.desc);

   always_comb begin
      case (cmd.wr_sel)
         WSEL_INPUT: wdata = '{value: req_value, index: IDX_W'(cmd.wr_addr)};
         WSEL_HOLD:  wdata = hold_ff;
         WSEL_PICK:  wdata = pick;
         WSEL_RDA:   wdata = rda_ff;
         default:    wdata = rda_ff;
      endcase
   end

   assign hold_in = (cmd.hold_sel == HSEL_RDB) ? rdb_ff : rda_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= wdata;
      end
      rda_ff <= mem[cmd.rd_a[AW-1:0]];
      rdb_ff <= mem[cmd.rd_b[AW-1:0]];
      if (cmd.hold_ld) begin
         hold_ff <= hold_in;
      end
      if (cmd.out_ld) begin
         out_value <= rda_ff.value;
         out_index <= rda_ff.index;
         out_end   <= cmd.out_end;
         out_ovf   <= cmd.out_ovf;
      end
   end

endmodule

// ===== rtl/hsa_ctrl.sv =====
`timescale 1ns / 1ps
module hsa_ctrl #(
   parameter int MAX_ROW = hsa_pkg::MAX_ROW_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output hsa_pkg::cmd_type cmd,
   input  hsa_pkg::sts_type sts
);
   import hsa_pkg::*;

   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int CW = $clog2(MAX_ROW + 1);
   localparam int LW = CW + 1;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_BUILD     = 4'd1;
   localparam logic [3:0] ST_HOLD      = 4'd2;
   localparam logic [3:0] ST_CHECK     = 4'd3;
   localparam logic [3:0] ST_PICK      = 4'd4;
   localparam logic [3:0] ST_POP       = 4'd5;
   localparam logic [3:0] ST_POP2      = 4'd6;
   localparam logic [3:0] ST_EMIT_RD   = 4'd7;
   localparam logic [3:0] ST_EMIT_LD   = 4'd8;
   localparam logic [3:0] ST_EMIT_WAIT = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic          desc_ff;
   logic          sort_desc_ff, sort_desc_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] size_ff, size_in;
   logic [AW-1:0] node_ff, node_in;
   logic [AW-1:0] dad_ff, dad_in;
   logic          build_ff, build_in;
   logic [AW-1:0] k_ff, k_in;

   logic [LW-1:0] left;
   logic [LW-1:0] right;
   logic [CW-1:0] half;
   logic          full;
   logic          k_last;

   assign left   = LW'({node_ff, 1'b1});
   assign right  = left + LW'(1);
   assign half   = n_ff >> 1;
   assign full   = (count_ff >= CW'(MAX_ROW));
   assign k_last = ((CW'(k_ff) + CW'(1)) == n_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT_WAIT);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      sort_desc_in = sort_desc_ff;
      n_in         = n_ff;
      size_in      = size_ff;
      node_in      = node_ff;
      dad_in       = dad_ff;
      build_in     = build_ff;
      k_in         = k_ff;
      cmd          = '0;
      cmd.desc     = sort_desc_ff;
      cmd.wr_addr  = ADDR_W'(node_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!full) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_sel  = WSEL_INPUT;
                  cmd.wr_addr = ADDR_W'(count_ff);
                  count_in    = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  n_in         = full ? count_ff : count_ff + CW'(1);
                  sort_desc_in = desc_ff;
                  state_in     = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            size_in = n_ff;
            if (half == '0) begin
               state_in = ST_POP;
            end else begin
               dad_in   = AW'(half - CW'(1));
               cmd.rd_a = ADDR_W'(half - CW'(1));
               build_in = 1'b1;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            cmd.hold_ld  = 1'b1;
            cmd.hold_sel = HSEL_RDA;
            node_in      = dad_ff;
            state_in     = ST_CHECK;
         end
         ST_CHECK, ST_PICK: begin
            if ((state_ff == ST_CHECK) && (left < LW'(size_ff))) begin
               cmd.rd_a = ADDR_W'(left);
               cmd.rd_b = ADDR_W'(right);
               state_in = ST_PICK;
            end else if ((state_ff == ST_PICK) && sts.sift_on) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WSEL_PICK;
               node_in    = sts.pick_right ? AW'(right) : AW'(left);
               state_in   = ST_CHECK;
            end else begin
               // sift done: drop the held pair into its slot
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WSEL_HOLD;
               if (build_ff && (dad_ff != '0)) begin
                  dad_in   = dad_ff - AW'(1);
                  cmd.rd_a = ADDR_W'(dad_ff - AW'(1));
                  state_in = ST_HOLD;
               end else begin
                  build_in = 1'b0;
                  state_in = ST_POP;
               end
            end
            if (state_ff == ST_PICK) begin
               cmd.right_ok = (right < LW'(size_ff));
            end
         end
         ST_POP: begin
            if (size_ff == '0) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               size_in  = size_ff - CW'(1);
               cmd.rd_a = '0;
               cmd.rd_b = ADDR_W'(size_ff - CW'(1));
               state_in = ST_POP2;
            end
         end
         ST_POP2: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = WSEL_RDA;
            cmd.wr_addr  = ADDR_W'(size_ff);
            cmd.hold_ld  = 1'b1;
            cmd.hold_sel = HSEL_RDB;
            node_in      = '0;
            state_in     = ST_CHECK;
         end
         ST_EMIT_RD: begin
            cmd.rd_a = ADDR_W'(k_ff);
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.out_ld  = 1'b1;
            cmd.out_end = k_last;
            cmd.out_ovf = drop_ff;
            state_in    = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (k_last) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         desc_ff  <= ASCENDING;
         build_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         build_ff <= build_in;
         if (csr_we) begin
            desc_ff <= csr_wdata;
         end
      end
      sort_desc_ff <= sort_desc_in;
      n_ff         <= n_in;
      size_ff      <= size_in;
      node_ff      <= node_in;
      dad_ff       <= dad_in;
      k_ff         <= k_in;
   end

endmodule
